### sv/parallax_grid_pixel_generator_assert.svh
// Assertion macros for the parallax grid pixel generator.
`ifndef PARALLAX_GRID_PIXEL_GENERATOR_ASSERT_SVH
`define PARALLAX_GRID_PIXEL_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PGPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PGPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Fixed-latency implication.
`define PGPG_ASSERT_LAT(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);
`else
`define PGPG_ASSERT_IMP(label, ante, cons, msg)
`define PGPG_ASSERT_NEXT(label, ante, cons, msg)
`define PGPG_ASSERT_LAT(label, ante, n, cons, msg)
`endif
`endif

### sv/pgpg_pkg.sv
// Shared types and constants of the parallax grid pixel generator.
package pgpg_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 192;

  // Cell pitch in pixels per layer.
  localparam int CELL_FAR  = 96;
  localparam int CELL_MID  = 32;
  localparam int CELL_FINE = 8;

  // Line thickness in pixels; major mid lines add one.
  localparam int THICK_FAR  = 2;
  localparam int THICK_MID  = 2;
  localparam int THICK_FINE = 1;

  // Parallax factors, unsigned 0.16.
  localparam logic [15:0] PAR_FAR  = 16'd11796;
  localparam logic [15:0] PAR_MID  = 16'd19661;
  localparam logic [15:0] PAR_FINE = 16'd36045;

  localparam int SCROLL_W    = 24;
  localparam int COLOR_W     = 32;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCROLL_X        = 3'd0,
    REG_SCROLL_Y        = 3'd1,
    REG_PAPER_COLOR     = 3'd2,
    REG_FAR_COLOR       = 3'd3,
    REG_MID_COLOR       = 3'd4,
    REG_MID_MAJOR_COLOR = 3'd5,
    REG_FINE_COLOR      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SCROLL_W-1:0] scroll_x;
    logic [SCROLL_W-1:0] scroll_y;
    logic [COLOR_W-1:0]  paper_color;
    logic [COLOR_W-1:0]  far_color;
    logic [COLOR_W-1:0]  mid_color;
    logic [COLOR_W-1:0]  mid_major_color;
    logic [COLOR_W-1:0]  fine_color;
  } cfg_t;

  // Line coverage of one axis.
  typedef struct packed {
    logic far;
    logic mid;
    logic major;
    logic fine;
  } hit_t;

  // Control traveling with a pixel.
  typedef struct packed {
    logic valid;
    logic oob;
  } ctl_t;

  typedef enum logic [1:0] {
    LAYER_NONE = 2'd0,
    LAYER_FAR  = 2'd1,
    LAYER_MID  = 2'd2,
    LAYER_FINE = 2'd3
  } layer_t;

endpackage

### sv/pgpg_regfile.sv
// Configuration register file of the parallax grid pixel generator.
module pgpg_regfile (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pgpg_pkg::COLOR_W-1:0]        cfg_data,
  output pgpg_pkg::cfg_t                      cfg
);

  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgpg_pkg::REG_SCROLL_X:        cfg.scroll_x <= cfg_data[pgpg_pkg::SCROLL_W-1:0];
        pgpg_pkg::REG_SCROLL_Y:        cfg.scroll_y <= cfg_data[pgpg_pkg::SCROLL_W-1:0];
        pgpg_pkg::REG_PAPER_COLOR:     cfg.paper_color <= cfg_data;
        pgpg_pkg::REG_FAR_COLOR:       cfg.far_color <= cfg_data;
        pgpg_pkg::REG_MID_COLOR:       cfg.mid_color <= cfg_data;
        pgpg_pkg::REG_MID_MAJOR_COLOR: cfg.mid_major_color <= cfg_data;
        pgpg_pkg::REG_FINE_COLOR:      cfg.fine_color <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/pgpg_axis.sv
// Three-stage line coverage pipeline for one screen axis, all three layers.
module pgpg_axis (
  input  logic                          clk,
  input  logic [pgpg_pkg::SCROLL_W-1:0] scroll,
  input  logic [7:0]                    pos,
  output pgpg_pkg::hit_t                hit
);

  // 11-bit value mod 3: base-4 digit sum, then fold.
  function automatic logic [1:0] mod3_11(input logic [10:0] v);
    logic [11:0] w;
    logic [4:0]  s;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + 5'(w[2*i +: 2]);
    end
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6)  s = s - 5'd6;
    if (s >= 5'd3)  s = s - 5'd3;
    return s[1:0];
  endfunction

  // Offset into a far cell; input stays below four cells.
  function automatic logic [6:0] mod_far(input logic [8:0] v);
    logic [8:0] t;
    if (v >= 9'(3 * pgpg_pkg::CELL_FAR))      t = v - 9'(3 * pgpg_pkg::CELL_FAR);
    else if (v >= 9'(2 * pgpg_pkg::CELL_FAR)) t = v - 9'(2 * pgpg_pkg::CELL_FAR);
    else if (v >= 9'(pgpg_pkg::CELL_FAR))     t = v - 9'(pgpg_pkg::CELL_FAR);
    else                                      t = v;
    return t[6:0];
  endfunction

  // Stage 1: |scroll| * parallax, kept as 16.8 magnitude.
  logic [23:0] abs_scroll;
  logic [39:0] prod_far, prod_mid, prod_fine;
  logic [23:0] mag_far, mag_mid, mag_fine;
  logic        nonneg1;
  logic [7:0]  pos1;

  assign abs_scroll = scroll[23] ? (~scroll + 24'd1) : scroll;
  assign prod_far   = 40'(abs_scroll) * 40'(pgpg_pkg::PAR_FAR);
  assign prod_mid   = 40'(abs_scroll) * 40'(pgpg_pkg::PAR_MID);
  assign prod_fine  = 40'(abs_scroll) * 40'(pgpg_pkg::PAR_FINE);

  always_ff @(posedge clk) begin
    mag_far  <= prod_far[39:16];
    mag_mid  <= prod_mid[39:16];
    mag_fine <= prod_fine[39:16];
    nonneg1  <= ~scroll[23];
    pos1     <= pos;
  end

  // Stage 2: distance from first line to pixel 0, and mid line index phase.
  // Mid and fine cells are powers of two (32, 8): remainders are bit fields.
  logic [15:0] int_far, int_mid;
  logic [6:0]  r_far;
  logic [4:0]  r_mid;
  logic [2:0]  r_fine;
  logic        mid_carry;
  logic [6:0]  adj_far_next;
  logic [4:0]  adj_mid_next;
  logic [2:0]  adj_fine_next;
  logic [1:0]  idx0_next;
  logic [6:0]  adj_far;
  logic [4:0]  adj_mid;
  logic [2:0]  adj_fine;
  logic [1:0]  idx0;
  logic [7:0]  pos2;

  assign int_far   = mag_far[23:8];
  assign int_mid   = mag_mid[23:8];
  assign r_far     = {mod3_11(int_far[15:5]), int_far[4:0]};
  assign r_mid     = int_mid[4:0];
  assign r_fine    = mag_fine[10:8];
  assign mid_carry = (r_mid != 5'd0) || (mag_mid[7:0] != 8'd0);

  always_comb begin
    if (nonneg1) begin
      // View moved right/down: lines shift toward negative coordinates.
      adj_far_next  = r_far;
      adj_mid_next  = r_mid;
      adj_fine_next = r_fine;
      idx0_next     = 2'd0 - (int_mid[6:5] + 2'(mid_carry));
    end else begin
      adj_far_next  = (r_far != 7'd0) ? 7'(pgpg_pkg::CELL_FAR) - r_far : 7'd0;
      adj_mid_next  = 5'd0 - r_mid;
      adj_fine_next = 3'd0 - r_fine;
      idx0_next     = int_mid[6:5];
    end
  end

  always_ff @(posedge clk) begin
    adj_far  <= adj_far_next;
    adj_mid  <= adj_mid_next;
    adj_fine <= adj_fine_next;
    idx0     <= idx0_next;
    pos2     <= pos1;
  end

  // Stage 3: offset inside the cell against line thickness.
  logic [8:0]   d_far, d_mid, d_fine;
  logic [1:0]   idx_mid;
  logic         major;
  logic [4:0]   thick_mid;
  pgpg_pkg::hit_t hit_next;

  assign d_far     = 9'(pos2) + 9'(adj_far);
  assign d_mid     = 9'(pos2) + 9'(adj_mid);
  assign d_fine    = 9'(pos2) + 9'(adj_fine);
  assign idx_mid   = idx0 + d_mid[6:5];
  assign major     = (idx_mid == 2'd0);
  assign thick_mid = major ? 5'(pgpg_pkg::THICK_MID + 1) : 5'(pgpg_pkg::THICK_MID);

  always_comb begin
    hit_next.far   = mod_far(d_far) < 7'(pgpg_pkg::THICK_FAR);
    hit_next.mid   = d_mid[4:0] < thick_mid;
    hit_next.major = major;
    hit_next.fine  = d_fine[2:0] < 3'(pgpg_pkg::THICK_FINE);
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

endmodule

### sv/pgpg_resolve.sv
// Layer priority and output register of the parallax grid pixel generator.
`include "parallax_grid_pixel_generator_assert.svh"

module pgpg_resolve (
  input  logic                         clk,
  input  logic                         rst,
  input  pgpg_pkg::ctl_t               ctl,
  input  pgpg_pkg::hit_t               hit_x,
  input  pgpg_pkg::hit_t               hit_y,
  input  pgpg_pkg::cfg_t               cfg,
  output logic                         done,
  output logic [pgpg_pkg::COLOR_W-1:0] pixel_color
);

  function automatic pgpg_pkg::layer_t top_layer(input pgpg_pkg::hit_t h);
    if (h.fine)     return pgpg_pkg::LAYER_FINE;
    else if (h.mid) return pgpg_pkg::LAYER_MID;
    else if (h.far) return pgpg_pkg::LAYER_FAR;
    else            return pgpg_pkg::LAYER_NONE;
  endfunction

  function automatic logic [pgpg_pkg::COLOR_W-1:0] layer_color(
    input pgpg_pkg::layer_t l, input logic major, input pgpg_pkg::cfg_t c);
    logic [pgpg_pkg::COLOR_W-1:0] col;
    case (l)
      pgpg_pkg::LAYER_FAR:  col = c.far_color;
      pgpg_pkg::LAYER_MID:  col = major ? c.mid_major_color : c.mid_color;
      pgpg_pkg::LAYER_FINE: col = c.fine_color;
      default:              col = c.paper_color;
    endcase
    return col;
  endfunction

  pgpg_pkg::layer_t             lay_x, lay_y;
  logic [pgpg_pkg::COLOR_W-1:0] color_next;

  assign lay_x = top_layer(hit_x);
  assign lay_y = top_layer(hit_y);

  // Vertical lines win ties within a layer.
  always_comb begin
    if (ctl.oob) begin
      color_next = cfg.paper_color;
    end else if (lay_x != pgpg_pkg::LAYER_NONE && lay_x >= lay_y) begin
      color_next = layer_color(lay_x, hit_x.major, cfg);
    end else begin
      color_next = layer_color(lay_y, hit_y.major, cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_color <= color_next;
  end

  `PGPG_ASSERT_NEXT(a_oob_paper, ctl.valid && ctl.oob, pixel_color == $past(cfg.paper_color), "off-screen pixel not paper")
  `PGPG_ASSERT_NEXT(a_fine_x_wins, ctl.valid && !ctl.oob && hit_x.fine, pixel_color == $past(cfg.fine_color), "fine vertical line lost priority")
  `PGPG_ASSERT_NEXT(a_blank_paper, ctl.valid && hit_x == '0 && hit_y == '0, pixel_color == $past(cfg.paper_color), "uncovered pixel not paper")

endmodule

### sv/parallax_grid_pixel_generator.sv
// Top level of the parallax grid pixel generator.
//
// Usage:
//   Pixel requests: drive pixel_x / pixel_y and raise start; the transaction
//   is taken at a rising edge with start high and busy low. busy is high only
//   during reset, so one pixel can be taken every clock.
//   Results: done pulses for one cycle with pixel_color. The receiver cannot
//   stall; results leave in request order, one per accepted pixel.
//   Path: the pixel passes the multiply, cell reduce, coverage and output
//   registers in that order before done rises.
//   Throughput: one pixel per clock; each stage, including the three 24x16
//   parallax multipliers per axis, is fully pipelined.
//   Configuration: cfg_valid / cfg_ready carry a register index and data;
//   write only while no pixel is in flight. Index 7 is ignored.
//   Reset: synchronous; zeroes config, control flags and done; drops any pixels
//   in flight. cfg_ready and busy show the block as unavailable during reset.
`include "parallax_grid_pixel_generator_assert.svh"

module parallax_grid_pixel_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       pixel_x,
  input  logic [7:0]                       pixel_y,
  output logic                             done,
  output logic [pgpg_pkg::COLOR_W-1:0]     pixel_color,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pgpg_pkg::COLOR_W-1:0]     cfg_data
);

  pgpg_pkg::cfg_t cfg;
  pgpg_pkg::hit_t hit_x, hit_y;
  pgpg_pkg::ctl_t ctl_in, ctl1, ctl2, ctl3;
  logic           accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Off-screen pixels still flow through and come out as paper.
  assign ctl_in.valid = accept;
  assign ctl_in.oob   = !((32'(pixel_x) < pgpg_pkg::SCREEN_WIDTH) &&
                          (32'(pixel_y) < pgpg_pkg::SCREEN_HEIGHT));

  pgpg_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Columns are tested against vertical lines, driven by scroll_x.
  pgpg_axis u_axis_x (
    .clk    (clk),
    .scroll (cfg.scroll_x),
    .pos    (pixel_x),
    .hit    (hit_x)
  );

  pgpg_axis u_axis_y (
    .clk    (clk),
    .scroll (cfg.scroll_y),
    .pos    (pixel_y),
    .hit    (hit_y)
  );

  // Valid and off-screen flags ride alongside the three axis stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  pgpg_resolve u_resolve (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl3),
    .hit_x       (hit_x),
    .hit_y       (hit_y),
    .cfg         (cfg),
    .done        (done),
    .pixel_color (pixel_color)
  );

  `PGPG_ASSERT_LAT(a_req_to_done, start && !busy, 4, done, "accepted pixel produced no result")
  `PGPG_ASSERT_IMP(a_done_had_req, done, $past(start && !busy, 4), "result without a request")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the parallax grid pixel generator.
`timescale 1ns / 100ps

module tb_top;
  import pgpg_pkg::*;

  // Mid layer: every fourth line is a major one.
  localparam int MAJOR_EVERY = 4;
  // Cycles with no transaction at all before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Pipeline depth of the block: edges from the accepting edge to done.
  localparam int PIPE_DEPTH = 4;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_PIXELS = 150;

  // Index 7 decodes to no register; a write there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // Distinct line colors for the directed part, so that every layer is
  // recognizable in the output.
  localparam logic [COLOR_W-1:0] RESET_COLOR = '0;
  localparam logic [COLOR_W-1:0] C_PAPER = 32'h1111_1111;
  localparam logic [COLOR_W-1:0] C_FAR   = 32'h2222_2222;
  localparam logic [COLOR_W-1:0] C_MID   = 32'h3333_3333;
  localparam logic [COLOR_W-1:0] C_MAJOR = 32'h4444_4444;
  localparam logic [COLOR_W-1:0] C_FINE  = 32'h5555_5555;

  // One row of the directed table: either a register write or a pixel
  // request, the latter optionally with its expected color typed in.
  typedef struct packed {
    logic                   reg_write;
    logic [CFG_INDEX_W-1:0] index;
    logic [COLOR_W-1:0]     data;
    logic [7:0]             x;
    logic [7:0]             y;
    logic                   typed;
    logic [COLOR_W-1:0]     color;
  } step_t;

  function automatic step_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [COLOR_W-1:0] val);
    step_t s;
    s = '0;
    s.reg_write = 1'b1;
    s.index = idx;
    s.data = val;
    return s;
  endfunction

  function automatic step_t pixel_row(logic [7:0] x, logic [7:0] y);
    step_t s;
    s = '0;
    s.x = x;
    s.y = y;
    return s;
  endfunction

  function automatic step_t known_row(logic [7:0] x, logic [7:0] y, logic [COLOR_W-1:0] c);
    step_t s;
    s = pixel_row(x, y);
    s.typed = 1'b1;
    s.color = c;
    return s;
  endfunction

  localparam int DIRECTED_ROWS = 32;

  // Directed sequence. With zero scroll every layer has a line at 0 and the
  // mid line at 0 is major, so the typed colors follow from pos % cell.
  step_t directed_steps [DIRECTED_ROWS] = '{
    known_row(8'd0, 8'd0, RESET_COLOR),         // all registers clear after reset
    cfg_row(REG_PAPER_COLOR, C_PAPER),
    cfg_row(REG_FAR_COLOR, C_FAR),
    cfg_row(REG_MID_COLOR, C_MID),
    cfg_row(REG_MID_MAJOR_COLOR, C_MAJOR),
    cfg_row(REG_FINE_COLOR, C_FINE),
    known_row(8'd4, 8'd4, C_PAPER),             // between all lines
    known_row(8'd0, 8'd0, C_FINE),              // fine sits on top of everything
    known_row(8'd2, 8'd4, C_MAJOR),             // third pixel of the major line
    known_row(8'd33, 8'd4, C_MID),              // ordinary mid line
    known_row(8'd8, 8'd4, C_FINE),              // vertical fine line
    known_row(8'd4, 8'd1, C_MAJOR),             // horizontal major line only
    known_row(8'd40, 8'd33, C_FINE),            // vertical fine over horizontal mid
    pixel_row(8'd193, 8'd4),                    // far line hidden under mid
    known_row(8'd255, 8'd191, C_PAPER),         // last on-screen pixel
    known_row(8'd4, 8'd192, C_PAPER),           // first row below the screen
    known_row(8'd255, 8'd255, C_PAPER),         // far off screen
    cfg_row(REG_SPARE, 32'hFFFF_FFFF),          // unmapped index, dropped
    known_row(8'd4, 8'd4, C_PAPER),
    cfg_row(REG_SCROLL_X, 32'h0000_0001),       // scaled scroll truncates to zero
    cfg_row(REG_SCROLL_Y, 32'h00FF_FFFF),       // same, negative
    pixel_row(8'd2, 8'd4),
    pixel_row(8'd4, 8'd1),
    cfg_row(REG_SCROLL_X, 32'h007F_FFFF),       // largest positive offset
    cfg_row(REG_SCROLL_Y, 32'h0080_0000),       // most negative offset
    pixel_row(8'd0, 8'd0),
    pixel_row(8'd1, 8'd1),
    pixel_row(8'd100, 8'd50),
    pixel_row(8'd255, 8'd191),
    pixel_row(8'd37, 8'd150),
    cfg_row(REG_SCROLL_X, 32'h0080_0000),
    pixel_row(8'd200, 8'd2)
  };

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [7:0]             pixel_x;
  logic [7:0]             pixel_y;
  logic                   done;
  logic [COLOR_W-1:0]     pixel_color;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]     cfg_data;

  // Our copy of the register file, updated on every accepted write.
  cfg_t shadow_regs;
  // Colors still owed by the block, oldest first.
  logic [COLOR_W-1:0] pending_colors [$];
  int error_count = 0;
  int quiet_cycles = 0;
  // Percent chance of an idle burst before each pixel request.
  int gap_pct;
  logic [COLOR_W-1:0] want;

  parallax_grid_pixel_generator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .done        (done),
    .pixel_color (pixel_color),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Color prediction
  // ---------------------------------------------------------------------

  // Does a line of one layer cover coordinate pos along one axis?
  // The scaled scroll is -offset * parallax, truncated toward zero to 8
  // fraction bits. The first line sits at the integer part of its remainder
  // mod cell (moved to the left of the origin when positive), and its index
  // is floor(s / cell).
  function automatic bit axis_line(layer_t lay, logic [SCROLL_W-1:0] scroll, int pos,
                                   output logic [COLOR_W-1:0] col);
    longint off, mag_abs, mag, pitch, unit, rem, first, idx0, d, o, idx, par;
    int thick;
    bit major;
    case (lay)
      LAYER_FAR: begin
        pitch = longint'(CELL_FAR);
        thick = THICK_FAR;
        par = longint'(PAR_FAR);
      end
      LAYER_MID: begin
        pitch = longint'(CELL_MID);
        thick = THICK_MID;
        par = longint'(PAR_MID);
      end
      default: begin
        pitch = longint'(CELL_FINE);
        thick = THICK_FINE;
        par = longint'(PAR_FINE);
      end
    endcase
    off = longint'($signed(scroll));
    mag_abs = (off < 0) ? -off : off;
    mag = (mag_abs * par) / 65536;
    unit = pitch * 256;
    rem = (mag / 256) % pitch;
    if (off > 0) begin
      // s is negative: the remainder carries the sign; index rounds down
      first = -rem;
      idx0 = -((mag + unit - 1) / unit);
    end else begin
      first = (rem != 0) ? rem - pitch : 0;
      idx0 = mag / unit;
    end
    d = longint'(pos) - first;
    o = d % pitch;
    idx = idx0 + d / pitch;
    major = (lay == LAYER_MID) && (idx % MAJOR_EVERY == 0);
    if (major) thick++;
    case (lay)
      LAYER_FAR: col = shadow_regs.far_color;
      LAYER_MID: col = major ? shadow_regs.mid_major_color : shadow_regs.mid_color;
      default:   col = shadow_regs.fine_color;
    endcase
    return o < thick;
  endfunction

  // Horizontal lines first, recording the highest layer hit; a vertical line
  // then wins if its layer is at least as high.
  function automatic logic [COLOR_W-1:0] grid_color(logic [7:0] x, logic [7:0] y);
    logic [COLOR_W-1:0] result, col;
    layer_t top;
    layer_t lay;
    result = shadow_regs.paper_color;
    top = LAYER_NONE;
    if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
      for (int i = LAYER_FAR; i <= LAYER_FINE; i++) begin
        lay = layer_t'(i);
        if (axis_line(lay, shadow_regs.scroll_y, int'(y), col)) begin
          top = lay;
          result = col;
        end
      end
      for (int i = LAYER_FAR; i <= LAYER_FINE; i++) begin
        lay = layer_t'(i);
        if (lay >= top && axis_line(lay, shadow_regs.scroll_x, int'(x), col))
          result = col;
      end
    end
    return result;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // One pixel request. The idle burst, if any, lowers start once; start is
  // then held until an edge sees busy low, which is the accepting edge.
  task automatic request_pixel(logic [7:0] x, logic [7:0] y, bit typed,
                               logic [COLOR_W-1:0] color);
    logic [COLOR_W-1:0] owed;
    cfg_valid <= 1'b0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    owed = typed ? color : grid_color(x, y);
    pending_colors.insert(pending_colors.size(), owed);
  endtask

  // Stop requesting and wait for every owed color. Registers may only change
  // with nothing in flight.
  task automatic drain_pixels();
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // One register write transaction. cfg_valid is left high so that back to
  // back writes never lower and raise it at the same edge.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COLOR_W-1:0] val);
    if ($urandom_range(3) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCROLL_X:        shadow_regs.scroll_x = val[SCROLL_W-1:0];
      REG_SCROLL_Y:        shadow_regs.scroll_y = val[SCROLL_W-1:0];
      REG_PAPER_COLOR:     shadow_regs.paper_color = val;
      REG_FAR_COLOR:       shadow_regs.far_color = val;
      REG_MID_COLOR:       shadow_regs.mid_color = val;
      REG_MID_MAJOR_COLOR: shadow_regs.mid_major_color = val;
      REG_FINE_COLOR:      shadow_regs.fine_color = val;
      default: ;
    endcase
  endtask

  // Scroll values: the extremes, offsets so small they scale to nothing or
  // to a few pixels, and anything in the 24-bit range.
  function automatic logic [COLOR_W-1:0] pick_scroll();
    logic [SCROLL_W-1:0] s;
    case ($urandom_range(5))
      0: s = 24'h7F_FFFF;
      1: s = 24'h80_0000;
      2: s = 24'($urandom_range(0, 4000));
      3: s = 24'(-$urandom_range(0, 4000));
      default: s = 24'($urandom);
    endcase
    return {8'd0, s};
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: done is a one-cycle strobe the bench cannot stall, so
  // every strobe is taken at the edge that closes its cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: pixel_color expected none, actual %h", $time, pixel_color);
        error_count++;
      end else begin
        want = pending_colors.pop_front();
        if (pixel_color !== want) begin
          $display("%0t: pixel_color expected %h, actual %h", $time, want, pixel_color);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction on any side resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    start = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_regs = '0;
    gap_pct = 25;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table; each register write waits for the pipeline to empty.
    foreach (directed_steps[i]) begin
      if (directed_steps[i].reg_write) begin
        drain_pixels();
        write_reg(directed_steps[i].index, directed_steps[i].data);
      end else begin
        request_pixel(directed_steps[i].x, directed_steps[i].y,
                      directed_steps[i].typed, directed_steps[i].color);
      end
    end

    // Random phases, each under a fresh register setting. The first two pin
    // the scroll extremes on opposite axes; some phases run back to back
    // with no gaps, and so does the last one.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pixels();
      case (phase)
        0: begin
          write_reg(REG_SCROLL_X, 32'h007F_FFFF);
          write_reg(REG_SCROLL_Y, 32'h0080_0000);
        end
        1: begin
          write_reg(REG_SCROLL_X, 32'h0080_0000);
          write_reg(REG_SCROLL_Y, 32'h007F_FFFF);
        end
        default: begin
          write_reg(REG_SCROLL_X, pick_scroll());
          write_reg(REG_SCROLL_Y, pick_scroll());
        end
      endcase
      write_reg(REG_PAPER_COLOR, $urandom);
      write_reg(REG_FAR_COLOR, $urandom);
      write_reg(REG_MID_COLOR, $urandom);
      write_reg(REG_MID_MAJOR_COLOR, $urandom);
      write_reg(REG_FINE_COLOR, $urandom);
      if ($urandom_range(2) == 0) write_reg(REG_SPARE, $urandom);
      gap_pct = (phase == RANDOM_PHASES - 1 || phase % 3 == 1) ? 0 : 30;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // now and then hold off until the pipeline has emptied
        if (gap_pct > 0 && n > 0 && $urandom_range(60) == 0) drain_pixels();
        request_pixel(8'($urandom_range(255)),
                      8'(($urandom_range(9) == 0) ? $urandom_range(SCREEN_HEIGHT, 255)
                                                  : $urandom_range(SCREEN_HEIGHT - 1)),
                      1'b0, '0);
      end
    end

    drain_pixels();
    // a few more edges so that a stray extra strobe is still caught
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/pgpg_pkg.sv
sv/pgpg_regfile.sv
sv/pgpg_axis.sv
sv/pgpg_resolve.sv
sv/parallax_grid_pixel_generator.sv
tb/sv/tb_top.sv
